>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, sampled on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

>>> sv/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// Field widths, codes and control structs of the descriptor slot allocator
// ----------------------------------------------------------------------------
`default_nettype none

package dsa_pkg;

  // payload widths
  localparam int SLOT_W      = 10;
  localparam int LIMIT_W     = 11;
  localparam int STRIDE_W    = 13;
  localparam int ADDR_W      = 64;
  localparam int STATUS_W    = 2;
  localparam int LIVE_W      = 11;
  localparam int PROD_W      = SLOT_W + STRIDE_W;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 88;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SLOT   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NONE_LIVE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_LIMIT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_STRIDE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_BASE   = 2'd2;

  // configuration reset values
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 11'd1024;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd32;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic decide;
    logic mul;
    logic add;
    logic load;
  } dsa_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } dsa_sts_t;

endpackage

`default_nettype wire

>>> sv/dsa_ctrl.sv
// ----------------------------------------------------------------------------
// dsa_ctrl
// Request sequencer: capture, decide, multiply, add, hand off to output
// ----------------------------------------------------------------------------
`default_nettype none

module dsa_ctrl import dsa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  input  wire dsa_sts_t sts,
  output dsa_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

  state_t state;
  logic   in_beat;

  assign in_beat = s_tvalid && s_tready;

  // per-state commands
  always_comb begin
    cmd         = '0;
    cmd.capture = in_beat;
    cmd.decide  = (state == ST_DECIDE);
    cmd.mul     = (state == ST_MUL);
    cmd.add     = (state == ST_ADD);
    cmd.load    = (state == ST_DONE) && sts.out_free;
  end

  // state and ready register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s_tready <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            state    <= ST_DECIDE;
            s_tready <= 1'b0;
          end
        end
        ST_DECIDE: state <= ST_MUL;
        ST_MUL:    state <= ST_ADD;
        ST_ADD:    state <= ST_DONE;
        ST_DONE: begin
          if (sts.out_free) begin
            state    <= ST_IDLE;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          s_tready <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/dsa_datapath.sv
// ----------------------------------------------------------------------------
// dsa_datapath
// Config registers, slot counters, free stack memory, address math and
// the output register
// ----------------------------------------------------------------------------
`default_nettype none

module dsa_datapath import dsa_pkg::*; #(
  parameter int HEAP_DEPTH = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [SLOT_W-1:0]      req_slot_in,
  input  wire logic                   req_kind_in,
  input  wire dsa_cmd_t               cmd,
  output dsa_sts_t                    sts,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [M_TDATA_W-1:0]        m_tdata,
  output logic [STATUS_W-1:0]         m_tuser
);

  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(HEAP_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam int PAD_W = M_TDATA_W - SLOT_W - ADDR_W - LIVE_W;

  // configuration
  logic [LIMIT_W-1:0]  slot_limit;
  logic [STRIDE_W-1:0] slot_stride;
  logic [ADDR_W-1:0]   heap_base;

  // allocator state
  logic [CW-1:0] next_fresh;
  logic [CW-1:0] free_top;
  logic [CW-1:0] live_slots;
  logic [SLOT_W-1:0] free_stack [HEAP_DEPTH];

  // request and pipeline registers
  logic                req_kind;
  logic [SLOT_W-1:0]   req_slot;
  logic                grant;
  logic                use_pop;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   fresh_idx;
  logic [SLOT_W-1:0]   rd_data;
  logic [SLOT_W-1:0]   res_idx;
  logic [PROD_W-1:0]   product;
  logic [ADDR_W-1:0]   addr_sum;

  // decision terms
  logic [LW-1:0]     limit_ext;
  logic [LW-1:0]     eff_limit;
  logic              fresh_ok;
  logic              pop_ok;
  logic              live_zero;
  logic              do_pop;
  logic              do_push;
  logic [CW-1:0]     top_m1;
  logic [SLOT_W-1:0] idx_sel;

  assign limit_ext = LW'(slot_limit);
  assign eff_limit = (limit_ext > DEPTH_L) ? DEPTH_L : limit_ext;
  assign fresh_ok  = LW'(next_fresh) < eff_limit;
  assign pop_ok    = (free_top != '0);
  assign live_zero = (live_slots == '0);
  assign top_m1    = free_top - ONE_C;
  assign do_pop    = cmd.decide && (req_kind == KIND_ALLOC) && !fresh_ok && pop_ok;
  assign do_push   = cmd.decide && (req_kind == KIND_FREE) && !live_zero
                     && (free_top < DEPTH_C);
  assign idx_sel   = use_pop ? rd_data : fresh_idx;

  assign sts.out_free = !m_tvalid || m_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit  <= LIMIT_RESET;
      slot_stride <= STRIDE_RESET;
      heap_base   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SLOT_LIMIT:  slot_limit  <= cfg_data[LIMIT_W-1:0];
        CFG_SLOT_STRIDE: slot_stride <= cfg_data[STRIDE_W-1:0];
        CFG_HEAP_BASE:   heap_base   <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind <= req_kind_in;
      req_slot <= req_slot_in;
    end
  end

  // counters and decision
  always_ff @(posedge clk) begin
    if (rst) begin
      next_fresh <= '0;
      free_top   <= '0;
      live_slots <= '0;
    end else if (cmd.decide) begin
      if (req_kind == KIND_ALLOC) begin
        if (fresh_ok) begin
          next_fresh <= next_fresh + ONE_C;
          live_slots <= live_slots + ONE_C;
        end else if (pop_ok) begin
          free_top   <= top_m1;
          live_slots <= live_slots + ONE_C;
        end
      end else if (!live_zero) begin
        if (free_top < DEPTH_C) begin
          free_top <= free_top + ONE_C;
        end
        live_slots <= live_slots - ONE_C;
      end
    end
  end

  // result flags of the decision
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      fresh_idx <= SLOT_W'(next_fresh);
      use_pop   <= (req_kind == KIND_ALLOC) && !fresh_ok;
      if (req_kind == KIND_ALLOC) begin
        grant      <= fresh_ok || pop_ok;
        res_status <= (fresh_ok || pop_ok) ? STATUS_OK : STATUS_NO_SLOT;
      end else begin
        grant      <= 1'b0;
        res_status <= live_zero ? STATUS_NONE_LIVE : STATUS_OK;
      end
    end
  end

  // free stack memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (do_push) begin
      free_stack[free_top[AW-1:0]] <= req_slot;
    end
    if (do_pop) begin
      rd_data <= free_stack[top_m1[AW-1:0]];
    end
  end

  // index times stride
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      product <= PROD_W'(idx_sel) * PROD_W'(slot_stride);
      res_idx <= grant ? idx_sel : '0;
    end
  end

  // base plus offset
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      addr_sum <= grant ? (heap_base + ADDR_W'(product)) : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tdata <= {{PAD_W{1'b0}}, LIVE_W'(live_slots), addr_sum, res_idx};
      m_tuser <= res_status;
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> sv/descriptor_slot_allocator.sv
// A request is captured when accepted, then runs decide, multiply, add and output load in turn;
// the sequencer waits in the last step while the output is held, and takes no new request
// until the result is loaded into the output register.
// The free stack is a single memory with one write and one registered read port.
// Reset (rst, synchronous): counters cleared, stack empty, config to its defaults.
// ----------------------------------------------------------------------------
// descriptor_slot_allocator
// Bump allocator with a LIFO free stack for fixed-size descriptor slots
// ----------------------------------------------------------------------------
`default_nettype none

module descriptor_slot_allocator import dsa_pkg::*; #(
  parameter int HEAP_DEPTH = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration write channel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // request stream
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [S_TDATA_W-1:0]   s_tdata,   // [9:0] freed_slot, [15:10] zero
  input  wire logic [0:0]             s_tuser,   // [0] kind
  // result stream
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [M_TDATA_W-1:0]        m_tdata,   // [9:0] slot_index,
                                                 // [73:10] slot_address,
                                                 // [84:74] live_count, [87:85] zero
  output logic [STATUS_W-1:0]         m_tuser    // [1:0] status
);

  dsa_cmd_t cmd;
  dsa_sts_t sts;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  dsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dsa_datapath #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_slot_in (s_tdata[SLOT_W-1:0]),
    .req_kind_in (s_tuser[0]),
    .cmd         (cmd),
    .sts         (sts),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

`default_nettype wire

>>> sv/dsa_checker.sv
// ----------------------------------------------------------------------------
// dsa_checker
// Port-level checks on the allocator result stream, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dsa_checker import dsa_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata,
  input wire logic [STATUS_W-1:0]  m_tuser
);

  // no request is taken while an earlier one is still being worked on
  `ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

  // failed allocate carries neither index nor address
  `ASSERT_IMPL(a_no_slot_zero, m_tvalid && (m_tuser == STATUS_NO_SLOT), m_tdata[73:0] == '0)

  // a dropped free only happens with nothing live
  `ASSERT_IMPL(a_none_live_count, m_tvalid && (m_tuser == STATUS_NONE_LIVE), m_tdata[84:74] == '0)

  // stalled result beat holds
  `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind descriptor_slot_allocator dsa_checker u_dsa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
